/* hdl/steady_state_genetic_step_assert.svh */
// Assertion macros shared by the steady-state genetic step RTL
`ifndef STEADY_STATE_GENETIC_STEP_ASSERT_SVH
`define STEADY_STATE_GENETIC_STEP_ASSERT_SVH

// Check cons in the same cycle as ante, sampled on clk, off during reset
`define SSGA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ssga assertion failed");

// Check cons in the cycle after ante
`define SSGA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ssga assertion failed");

`endif

/* hdl/ssga_pkg.sv */
// Types, constants and helper functions of the steady-state genetic step
`timescale 1ns / 1ps
package ssga_pkg;

  localparam int IDX_W      = 5;
  localparam int POP_SIZE   = 1 << IDX_W;
  localparam int CHROM_BITS = 20;
  localparam int FIT_W      = $clog2(CHROM_BITS + 1);
  localparam int CUT_W      = 5;
  localparam int PC_LG      = $clog2(CHROM_BITS);
  localparam int PC_N       = 1 << PC_LG;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CHROM_BITS-1:0] chrom_t;
  typedef logic [FIT_W-1:0]      fit_t;
  typedef logic [CUT_W-1:0]      cut_t;

  typedef struct packed {
    fit_t   fit;
    chrom_t bits;
  } entry_t;

  typedef struct packed {
    logic en;
    idx_t addr;
    fit_t data;
  } fit_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PARENTS,
    ST_WRITE,
    ST_SETTLE,
    ST_RD_BEST,
    ST_OUT
  } state_t;

  // Ones count as a balanced adder tree
  function automatic fit_t ones(input chrom_t v);
    fit_t s [PC_N];
    for (int i = 0; i < PC_N; i++) s[i] = '0;
    for (int i = 0; i < CHROM_BITS; i++) s[i] = fit_t'(v[i]);
    for (int lvl = 0; lvl < PC_LG; lvl++) begin
      for (int i = 0; i < (PC_N >> (lvl + 1)); i++) begin
        s[i] = s[2*i] + s[2*i+1];
      end
    end
    return s[0];
  endfunction

endpackage

/* hdl/ssga_if.sv */
// Request and result channel interfaces of the steady-state genetic step
`timescale 1ns / 1ps
interface ssga_in_if;
  logic                 valid;
  logic                 ready;
  logic                 op;
  ssga_pkg::idx_t       load_index;
  ssga_pkg::chrom_t     load_bits;
  ssga_pkg::idx_t       pick_a;
  ssga_pkg::idx_t       pick_b;
  ssga_pkg::cut_t       cut_point;
  ssga_pkg::chrom_t     flip_mask;

  modport source (output valid, op, load_index, load_bits, pick_a, pick_b, cut_point,
                  flip_mask, input ready);
  modport sink   (input valid, op, load_index, load_bits, pick_a, pick_b, cut_point,
                  flip_mask, output ready);
endinterface

interface ssga_out_if;
  logic             valid;
  logic             ready;
  ssga_pkg::chrom_t best_bits;
  ssga_pkg::fit_t   best_fitness;
  ssga_pkg::idx_t   best_slot;
  ssga_pkg::fit_t   child_fitness;
  ssga_pkg::idx_t   replaced_slot;

  modport source (output valid, best_bits, best_fitness, best_slot, child_fitness,
                  replaced_slot, input ready);
  modport sink   (input valid, best_bits, best_fitness, best_slot, child_fitness,
                  replaced_slot, output ready);
endinterface

/* hdl/ssga_mem.sv */
// Generic RAM: one write port, two registered read ports
`timescale 1ns / 1ps
module ssga_mem #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* hdl/ssga_fit_bank.sv */
// Fitness register bank with registered first-minimum and first-maximum trees
`timescale 1ns / 1ps
module ssga_fit_bank (
  input  logic              clk,
  input  ssga_pkg::fit_wr_t wr,
  output ssga_pkg::idx_t    worst_r,
  output ssga_pkg::idx_t    best_r
);

  ssga_pkg::fit_t fit_r [ssga_pkg::POP_SIZE];

  ssga_pkg::fit_t mn_f [ssga_pkg::IDX_W+1][ssga_pkg::POP_SIZE];
  ssga_pkg::idx_t mn_i [ssga_pkg::IDX_W+1][ssga_pkg::POP_SIZE];
  ssga_pkg::fit_t mx_f [ssga_pkg::IDX_W+1][ssga_pkg::POP_SIZE];
  ssga_pkg::idx_t mx_i [ssga_pkg::IDX_W+1][ssga_pkg::POP_SIZE];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      fit_r[wr.addr] <= wr.data;
    end
  end

  // Left side wins ties so the lowest index survives
  always_comb begin
    for (int l = 0; l <= ssga_pkg::IDX_W; l++) begin
      for (int i = 0; i < ssga_pkg::POP_SIZE; i++) begin
        mn_f[l][i] = '0;
        mn_i[l][i] = '0;
        mx_f[l][i] = '0;
        mx_i[l][i] = '0;
      end
    end
    for (int i = 0; i < ssga_pkg::POP_SIZE; i++) begin
      mn_f[0][i] = fit_r[i];
      mn_i[0][i] = ssga_pkg::idx_t'(i);
      mx_f[0][i] = fit_r[i];
      mx_i[0][i] = ssga_pkg::idx_t'(i);
    end
    for (int l = 0; l < ssga_pkg::IDX_W; l++) begin
      for (int i = 0; i < (ssga_pkg::POP_SIZE >> (l + 1)); i++) begin
        if (mn_f[l][2*i+1] < mn_f[l][2*i]) begin
          mn_f[l+1][i] = mn_f[l][2*i+1];
          mn_i[l+1][i] = mn_i[l][2*i+1];
        end else begin
          mn_f[l+1][i] = mn_f[l][2*i];
          mn_i[l+1][i] = mn_i[l][2*i];
        end
        if (mx_f[l][2*i+1] > mx_f[l][2*i]) begin
          mx_f[l+1][i] = mx_f[l][2*i+1];
          mx_i[l+1][i] = mx_i[l][2*i+1];
        end else begin
          mx_f[l+1][i] = mx_f[l][2*i];
          mx_i[l+1][i] = mx_i[l][2*i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    worst_r <= mn_i[ssga_pkg::IDX_W][0];
    best_r  <= mx_i[ssga_pkg::IDX_W][0];
  end

endmodule

/* hdl/ssga_breed.sv */
// Tournament, one-point crossover and mutation; child register and its ones count
`timescale 1ns / 1ps
module ssga_breed (
  input  logic              clk,
  input  logic              load,
  input  ssga_pkg::entry_t  par_a,
  input  ssga_pkg::entry_t  par_b,
  input  ssga_pkg::cut_t    cut,
  input  ssga_pkg::chrom_t  mask,
  output ssga_pkg::chrom_t  child_r,
  output ssga_pkg::fit_t    child_fit
);

  ssga_pkg::chrom_t win_bits;
  ssga_pkg::chrom_t lose_bits;
  ssga_pkg::chrom_t low;
  ssga_pkg::chrom_t child_nxt;

  always_comb begin
    // Tie goes to the second pick
    if (par_a.fit > par_b.fit) begin
      win_bits  = par_a.bits;
      lose_bits = par_b.bits;
    end else begin
      win_bits  = par_b.bits;
      lose_bits = par_a.bits;
    end
    if (int'(cut) >= ssga_pkg::CHROM_BITS) begin
      low = '1;
    end else begin
      low = (ssga_pkg::chrom_t'(1) << cut) - ssga_pkg::chrom_t'(1);
    end
    child_nxt = ((win_bits & low) | (lose_bits & ~low)) ^ mask;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      child_r <= child_nxt;
    end
  end

  assign child_fit = ssga_pkg::ones(child_r);

endmodule

/* hdl/steady_state_genetic_step.sv */
// Top level of the steady-state genetic step on the ones-count problem
//
//   channel | dir | handshake   | carries
//   in_ch   | in  | valid/ready | op, load_index, load_bits, pick_a, pick_b, cut_point, flip_mask
//   out_ch  | out | valid/ready | best_bits, best_fitness, best_slot, child_fitness, replaced_slot
//
// A load request is written as it is taken; the next one is taken in the following cycle.
// A generation request passes these steps until its result sits in the output register:
// parent read, breed, writeback, search tree settle, best read, output. Two trips
// through the population RAM read latency and the registered fitness trees set these steps.
// Reset (rst_n low, synchronous) clears the sequencer and the output valid only.
// A result waiting on out_ch does not block loads; a second result waits in ST_OUT.
`timescale 1ns / 1ps
module steady_state_genetic_step (
  input  logic       clk,
  input  logic       rst_n,
  ssga_in_if.sink    in_ch,
  ssga_out_if.source out_ch
);

  `include "steady_state_genetic_step_assert.svh"

  ssga_pkg::state_t  state_r, state_nxt;
  logic              in_fire, load_fire, gen_fire;

  ssga_pkg::cut_t    cut_r;
  ssga_pkg::chrom_t  mask_r;
  ssga_pkg::fit_t    cfit_r;
  ssga_pkg::idx_t    replaced_r;

  logic              out_valid_r;
  ssga_pkg::chrom_t  best_bits_r;
  ssga_pkg::fit_t    best_fit_r;
  ssga_pkg::idx_t    best_slot_r;
  ssga_pkg::fit_t    child_fit_r;
  ssga_pkg::idx_t    replaced_slot_r;
  logic              out_load;

  logic                               mem_we;
  ssga_pkg::idx_t                     mem_waddr;
  ssga_pkg::entry_t                   mem_wdata;
  ssga_pkg::idx_t                     raddr_a, raddr_b;
  logic [$bits(ssga_pkg::entry_t)-1:0] rdata_a, rdata_b;
  ssga_pkg::entry_t                   ent_a, ent_b;

  ssga_pkg::fit_wr_t fit_wr;
  ssga_pkg::idx_t    worst_r, best_r;
  ssga_pkg::chrom_t  child_r;
  ssga_pkg::fit_t    child_fit;
  logic              breed_load;

  assign in_ch.ready = (state_r == ssga_pkg::ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign load_fire   = in_fire && (in_ch.op == ssga_pkg::OP_LOAD);
  assign gen_fire    = in_fire && (in_ch.op == ssga_pkg::OP_GEN);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssga_pkg::ST_IDLE:    if (gen_fire) state_nxt = ssga_pkg::ST_PARENTS;
      ssga_pkg::ST_PARENTS: state_nxt = ssga_pkg::ST_WRITE;
      ssga_pkg::ST_WRITE:   state_nxt = ssga_pkg::ST_SETTLE;
      ssga_pkg::ST_SETTLE:  state_nxt = ssga_pkg::ST_RD_BEST;
      ssga_pkg::ST_RD_BEST: state_nxt = ssga_pkg::ST_OUT;
      ssga_pkg::ST_OUT:     if (!out_valid_r || out_ch.ready) state_nxt = ssga_pkg::ST_IDLE;
      default:              state_nxt = ssga_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssga_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Outputs of the sequencer
  always_comb begin
    breed_load = 1'b0;
    out_load   = 1'b0;
    unique case (state_r)
      ssga_pkg::ST_PARENTS: breed_load = 1'b1;
      ssga_pkg::ST_OUT:     out_load   = !out_valid_r || out_ch.ready;
      default: begin
        breed_load = 1'b0;
        out_load   = 1'b0;
      end
    endcase
  end

  // Read ports: parents on the request cycle, best entry afterwards
  assign raddr_a = (state_r == ssga_pkg::ST_IDLE) ? in_ch.pick_a : best_r;
  assign raddr_b = in_ch.pick_b;

  always_comb begin
    mem_we    = load_fire || (state_r == ssga_pkg::ST_WRITE);
    mem_waddr = worst_r;
    mem_wdata = '{fit: child_fit, bits: child_r};
    if (load_fire) begin
      mem_waddr = in_ch.load_index;
      mem_wdata = '{fit: ssga_pkg::ones(in_ch.load_bits), bits: in_ch.load_bits};
    end
  end

  assign fit_wr = '{en: mem_we, addr: mem_waddr, data: mem_wdata.fit};

  ssga_mem #(
    .WIDTH ($bits(ssga_pkg::entry_t)),
    .DEPTH (ssga_pkg::POP_SIZE)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign ent_a = ssga_pkg::entry_t'(rdata_a);
  assign ent_b = ssga_pkg::entry_t'(rdata_b);

  ssga_fit_bank u_bank (
    .clk     (clk),
    .wr      (fit_wr),
    .worst_r (worst_r),
    .best_r  (best_r)
  );

  ssga_breed u_breed (
    .clk       (clk),
    .load      (breed_load),
    .par_a     (ent_a),
    .par_b     (ent_b),
    .cut       (cut_r),
    .mask      (mask_r),
    .child_r   (child_r),
    .child_fit (child_fit)
  );

  // Hold request operands and writeback results
  always_ff @(posedge clk) begin
    if (gen_fire) begin
      cut_r  <= in_ch.cut_point;
      mask_r <= in_ch.flip_mask;
    end
    if (state_r == ssga_pkg::ST_WRITE) begin
      cfit_r     <= child_fit;
      replaced_r <= worst_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      best_bits_r     <= ent_a.bits;
      best_fit_r      <= ent_a.fit;
      best_slot_r     <= best_r;
      child_fit_r     <= cfit_r;
      replaced_slot_r <= replaced_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.best_bits     = best_bits_r;
  assign out_ch.best_fitness  = best_fit_r;
  assign out_ch.best_slot     = best_slot_r;
  assign out_ch.child_fitness = child_fit_r;
  assign out_ch.replaced_slot = replaced_slot_r;

  `SSGA_ASSERT_NOW(a_gen_reaches_out, gen_fire, ##5 (state_r == ssga_pkg::ST_OUT))
  `SSGA_ASSERT_NEXT(a_out_stall_holds,
                    (state_r == ssga_pkg::ST_OUT) && out_valid_r && !out_ch.ready,
                    state_r == ssga_pkg::ST_OUT)
  `SSGA_ASSERT_NOW(a_result_from_out, $rose(out_valid_r),
                   $past(state_r) == ssga_pkg::ST_OUT)

endmodule
